FILE: rtl/cfdb_pkg.sv
// Shared types, constants and the CRC byte step for the CRC-checked frame double buffer.
// No dependencies; imported by the frame store, the receive control, the top level and the testbench.
`default_nettype none

package cfdb_pkg;

    localparam int FRAME_BYTES_DEF = 64;
    localparam int BANK_STRIDE     = 64;
    localparam int MEM_DEPTH       = 2 * BANK_STRIDE;
    localparam int MEM_AW          = $clog2(MEM_DEPTH);
    localparam int POS_W           = 7;
    localparam int AGE_W           = 10;

    localparam logic [15:0]      CRC_INIT    = 16'hFFFF;
    localparam logic [15:0]      CRC_POLY    = 16'h8408;
    localparam logic [AGE_W-1:0] AGE_MAX     = 10'd1023;
    localparam logic [AGE_W-1:0] LIMIT_RESET = 10'd500;
    localparam logic [7:0]       MODE_MASK   = 8'h03;

    typedef enum logic [1:0] {
        KIND_RX_BYTE = 2'd0,
        KIND_TICK    = 2'd1,
        KIND_START   = 2'd2,
        KIND_READ    = 2'd3
    } kind_t;

    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        data;
    } mem_wr_t;

    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
    } mem_rd_t;

    typedef struct packed {
        logic       frame_checked;
        logic       crc_good;
        logic       stale;
        logic       accepted_bank;
        logic [1:0] mode_bits;
        logic [7:0] nav_status;
        logic       read_hit;
    } res_t;

    // Reflected CRC-16 over one byte, eight single-bit steps.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/cfdb_in_if.sv
// Input channel of the frame double buffer: valid/ready handshake and the input item.
// No dependencies.
`default_nettype none

interface cfdb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] rx_byte;
    logic [5:0] read_addr;

    modport source (output valid, output kind, output rx_byte, output read_addr, input ready);
    modport sink (input valid, input kind, input rx_byte, input read_addr, output ready);
endinterface

`default_nettype wire

FILE: rtl/cfdb_out_if.sv
// Output channel of the frame double buffer: valid/ready handshake and the result item.
// No dependencies.
`default_nettype none

interface cfdb_out_if;
    logic       valid;
    logic       ready;
    logic       frame_checked;
    logic       crc_good;
    logic       stale;
    logic       accepted_bank;
    logic [1:0] mode_bits;
    logic [7:0] nav_status;
    logic [7:0] read_data;

    modport source (output valid, output frame_checked, output crc_good, output stale,
                    output accepted_bank, output mode_bits, output nav_status,
                    output read_data, input ready);
    modport sink (input valid, input frame_checked, input crc_good, input stale,
                  input accepted_bank, input mode_bits, input nav_status,
                  input read_data, output ready);
endinterface

`default_nettype wire

FILE: rtl/cfdb_frame_mem.sv
// Two-bank frame store: one write port, one registered read port, per-entry valid bits.
// Depends on cfdb_pkg.
`default_nettype none

module cfdb_frame_mem
    import cfdb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire mem_wr_t    wr,
    input  wire mem_rd_t    rd,
    output logic      [7:0] rd_data
);

    logic [7:0]           mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] valid_reg;
    logic [7:0]           rd_data_reg;
    logic                 rd_ok_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    // An entry never written reads as zero, which matches the cleared store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.en)
            begin
                rd_ok_reg <= valid_reg[rd.addr];
            end
        end
    end

    assign rd_data = rd_ok_reg ? rd_data_reg : 8'h00;

endmodule

`default_nettype wire

FILE: rtl/cfdb_rx_ctrl.sv
// Receive control: byte position, CRC, bank selection, ageing and the shadowed mode/status bytes.
// Depends on cfdb_pkg; drives the frame store ports and the next result fields.
`default_nettype none

module cfdb_rx_ctrl
    import cfdb_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic       [1:0] kind,
    input  wire logic       [7:0] rx_byte,
    input  wire logic       [5:0] read_addr,
    input  wire logic             cfg_we,
    input  wire logic [AGE_W-1:0] cfg_wdata,
    output mem_wr_t               wr,
    output mem_rd_t               rd,
    output res_t                  res_next
);

    localparam int MODE_OFFSET   = (FRAME_BYTES >= 4) ? FRAME_BYTES - 4 : 0;
    localparam int STATUS_OFFSET = FRAME_BYTES - 3;

    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(FRAME_BYTES - 2);
    localparam logic [POS_W-1:0] POS_MODE   = POS_W'(MODE_OFFSET);
    localparam logic [POS_W-1:0] POS_STATUS = POS_W'(STATUS_OFFSET);
    localparam logic [POS_W-1:0] POS_END    = POS_W'(FRAME_BYTES);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       crc_low_reg, crc_low_next;
    logic             good_bank_reg, good_bank_next;
    logic             stale_reg, stale_next;
    logic [AGE_W-1:0] age_reg, age_next;
    logic [AGE_W-1:0] limit_reg;
    logic [1:0]       mode_reg [2];
    logic [1:0]       mode_next [2];
    logic [7:0]       status_reg [2];
    logic [7:0]       status_next [2];

    logic             inactive;
    logic [AGE_W-1:0] age_inc;
    kind_t            kind_in;

    assign inactive = ~good_bank_reg;
    assign kind_in  = kind_t'(kind);
    assign age_inc  = (age_reg != AGE_MAX) ? age_reg + 1'b1 : age_reg;

    always_comb
    begin
        pos_next     = pos_reg;
        crc_next     = crc_reg;
        crc_low_next = crc_low_reg;
        good_bank_next = good_bank_reg;
        stale_next   = stale_reg;
        age_next     = age_reg;
        mode_next    = mode_reg;
        status_next  = status_reg;
        wr           = '0;
        rd           = '0;
        res_next     = '0;

        if (accept)
        begin
            unique case (kind_in)
                KIND_RX_BYTE:
                begin
                    if (pos_reg <= POS_LAST)
                    begin
                        wr.en   = 1'b1;
                        wr.addr = {inactive, pos_reg[5:0]};
                        wr.data = rx_byte;
                        // Mode and status bytes are shadowed per bank so no extra read is needed.
                        if (pos_reg == POS_MODE)
                        begin
                            mode_next[inactive] = rx_byte[1:0] & MODE_MASK[1:0];
                        end
                        if (pos_reg == POS_STATUS)
                        begin
                            status_next[inactive] = rx_byte;
                        end
                        if (pos_reg < POS_CRC_LO)
                        begin
                            crc_next = crc_byte(crc_reg, rx_byte);
                            pos_next = pos_reg + 1'b1;
                        end
                        else if (pos_reg == POS_CRC_LO)
                        begin
                            crc_low_next = rx_byte;
                            pos_next     = pos_reg + 1'b1;
                        end
                        else
                        begin
                            res_next.frame_checked = 1'b1;
                            if ({rx_byte, crc_low_reg} == crc_reg)
                            begin
                                res_next.crc_good = 1'b1;
                                good_bank_next    = inactive;
                                stale_next        = 1'b0;
                                age_next          = '0;
                            end
                            pos_next = '0;
                            crc_next = CRC_INIT;
                        end
                    end
                    else
                    begin
                        pos_next = '0;
                        crc_next = CRC_INIT;
                    end
                end
                KIND_TICK:
                begin
                    age_next = age_inc;
                    if (age_inc > limit_reg)
                    begin
                        stale_next = 1'b1;
                    end
                end
                KIND_START:
                begin
                    pos_next = '0;
                    crc_next = CRC_INIT;
                end
                KIND_READ:
                begin
                    if ({1'b0, read_addr} < POS_END)
                    begin
                        rd.en   = 1'b1;
                        rd.addr = {good_bank_reg, read_addr};
                    end
                end
                default:
                begin
                    pos_next = pos_reg;
                end
            endcase
        end

        res_next.stale         = stale_next;
        res_next.accepted_bank = good_bank_next;
        res_next.mode_bits     = mode_next[good_bank_next];
        res_next.nav_status    = status_next[good_bank_next];
        res_next.read_hit      = rd.en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            crc_reg       <= CRC_INIT;
            crc_low_reg   <= '0;
            good_bank_reg <= 1'b0;
            stale_reg     <= 1'b1;
            age_reg       <= '0;
            limit_reg     <= LIMIT_RESET;
            mode_reg      <= '{default: '0};
            status_reg    <= '{default: '0};
        end
        else
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            crc_low_reg   <= crc_low_next;
            good_bank_reg <= good_bank_next;
            stale_reg     <= stale_next;
            age_reg       <= age_next;
            mode_reg      <= mode_next;
            status_reg    <= status_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/crc_checked_frame_double_buffer_top.sv
// Top level of the CRC-checked frame double buffer: channels, output register and frame store.
// Depends on cfdb_pkg, cfdb_in_if, cfdb_out_if, cfdb_frame_mem and cfdb_rx_ctrl.
`default_nettype none

// Frames of FRAME_BYTES bytes arrive one byte per input transfer and are written into the
// bank that does not hold the last good frame. A reflected CRC-16 (polynomial 0x8408, start
// value 0xFFFF) runs over all but the last two bytes, which carry the expected CRC low byte
// first; on a match the banks swap, the stale flag clears and the age returns to zero.
// Tick transfers age the data, and once the age exceeds the freshness limit the stale flag is
// set. Read transfers return a byte of the accepted bank. Every input transfer gives exactly
// one result transfer. Each accepted item is written to the output register, and a new
// item is taken in every cycle while the output register is empty or being drained; the
// frame store is a single memory with one write and one registered read port, and the mode
// and status bytes of each bank are kept in registers beside it so that a result needs at
// most one memory read. There is no clearing pass after reset: each store entry carries a
// valid bit and reads as zero until written.
module crc_checked_frame_double_buffer_top
    import cfdb_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    cfdb_in_if.sink               in_ch,
    cfdb_out_if.source            out_ch,
    input  wire logic             cfg_we,
    input  wire logic [AGE_W-1:0] cfg_wdata
);

    logic    accept;
    logic    out_valid_reg;
    res_t    res_next;
    res_t    res_reg;
    mem_wr_t wr;
    mem_rd_t rd;
    logic [7:0] mem_rd_data;

    // The input is taken whenever the output register is empty or is handing over its result.
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    cfdb_rx_ctrl #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .kind      (in_ch.kind),
        .rx_byte   (in_ch.rx_byte),
        .read_addr (in_ch.read_addr),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .wr        (wr),
        .rd        (rd),
        .res_next  (res_next)
    );

    // The memory read is issued with the accepted transfer, so its data lines up with the
    // output register; both hold while the output is stalled because nothing is accepted.
    cfdb_frame_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd      (rd),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.frame_checked = res_reg.frame_checked;
    assign out_ch.crc_good      = res_reg.crc_good;
    assign out_ch.stale         = res_reg.stale;
    assign out_ch.accepted_bank = res_reg.accepted_bank;
    assign out_ch.mode_bits     = res_reg.mode_bits;
    assign out_ch.nav_status    = res_reg.nav_status;
    assign out_ch.read_data     = res_reg.read_hit ? mem_rd_data : 8'h00;

endmodule

`default_nettype wire

FILE: rtl/cfdb_checker.sv
// Port-level checks for the CRC-checked frame double buffer, with the bind to the top level.
// Depends on crc_checked_frame_double_buffer_top and its channel interfaces.
`default_nettype none

module cfdb_checker
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_ready,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    input  wire logic       frame_checked,
    input  wire logic       crc_good,
    input  wire logic       stale,
    input  wire logic [7:0] read_data
);

    // A good CRC is only ever reported on a completed frame.
    a_good_needs_check: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && crc_good) |-> frame_checked)
        else $error("crc_good without frame_checked");

    // A swap to a good frame always leaves the data fresh.
    a_good_is_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && crc_good) |-> !stale)
        else $error("stale reported with a good frame");

    // With no result waiting the block always takes input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(read_data))
        else $error("read data changed while stalled");

endmodule

bind crc_checked_frame_double_buffer_top cfdb_checker u_cfdb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .frame_checked (out_ch.frame_checked),
    .crc_good      (out_ch.crc_good),
    .stale         (out_ch.stale),
    .read_data     (out_ch.read_data)
);

`default_nettype wire

FILE: test/tb_crc_checked_frame_double_buffer_top.sv
// Self-checking testbench for the CRC-checked frame double buffer, with its own receiver model.
// Depends on cfdb_pkg, cfdb_in_if, cfdb_out_if and crc_checked_frame_double_buffer_top.

module tb_crc_checked_frame_double_buffer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cfdb_pkg::*;

    localparam int FRAME_LEN     = FRAME_BYTES_DEF;
    localparam int MODE_AT       = (FRAME_LEN >= 4) ? FRAME_LEN - 4 : 0;
    localparam int STATUS_AT     = FRAME_LEN - 3;
    localparam int HOLD_CYCLES   = 240;
    localparam int DIRECTED_ROWS = 18;

    // One result item, with the read byte that the package result type leaves out.
    typedef struct packed {
        logic       frame_checked;
        logic       crc_good;
        logic       stale;
        logic       accepted_bank;
        logic [1:0] mode_bits;
        logic [7:0] nav_status;
        logic [7:0] read_data;
    } rx_result_t;

    // One row of the directed table. Where typed is set, want is the result to expect;
    // otherwise the model works the result out.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] rx_byte;
        logic [5:0] read_addr;
        logic       typed;
        rx_result_t want;
    } stim_row_t;

    // Straight after reset both banks are empty and the data is stale, so a result that
    // shows nothing of a new frame is all zero apart from the stale flag.
    localparam rx_result_t IDLE_RESULT = '{
        frame_checked: 1'b0, crc_good: 1'b0, stale: 1'b1, accepted_bank: 1'b0,
        mode_bits: 2'd0, nav_status: 8'h00, read_data: 8'h00
    };

    // The directed part: reset state at both address extremes, a tick that cannot clear the
    // stale flag, frame bytes at their extremes that land in the hidden bank, a frame start
    // that drops a partial frame, and reads of the mode and status offsets. Unused fields
    // carry extreme values so that they are shown to be ignored.
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{KIND_READ,    8'hFF, 6'd0,  1'b1, IDLE_RESULT},
        '{KIND_READ,    8'h00, 6'd63, 1'b1, IDLE_RESULT},
        '{KIND_TICK,    8'hFF, 6'd63, 1'b1, IDLE_RESULT},
        '{KIND_START,   8'hFF, 6'd63, 1'b1, IDLE_RESULT},
        '{KIND_RX_BYTE, 8'h00, 6'd63, 1'b1, IDLE_RESULT},
        '{KIND_RX_BYTE, 8'hFF, 6'd0,  1'b1, IDLE_RESULT},
        '{KIND_READ,    8'h00, 6'd1,  1'b1, IDLE_RESULT},
        '{KIND_RX_BYTE, 8'hA5, 6'd21, 1'b0, '0},
        '{KIND_START,   8'h00, 6'd0,  1'b0, '0},
        '{KIND_RX_BYTE, 8'h5A, 6'd42, 1'b0, '0},
        '{KIND_RX_BYTE, 8'h80, 6'd32, 1'b0, '0},
        '{KIND_RX_BYTE, 8'h01, 6'd31, 1'b0, '0},
        '{KIND_TICK,    8'h00, 6'd0,  1'b0, '0},
        '{KIND_READ,    8'h3C, 6'd32, 1'b0, '0},
        '{KIND_START,   8'hC3, 6'd17, 1'b0, '0},
        '{KIND_READ,    8'h00, 6'd62, 1'b0, '0},
        '{KIND_READ,    8'h00, 6'd60, 1'b0, '0},
        '{KIND_READ,    8'h00, 6'd61, 1'b0, '0}
    };

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [AGE_W-1:0] cfg_wdata;

    cfdb_in_if  in_ch ();
    cfdb_out_if out_ch ();

    crc_checked_frame_double_buffer_top #(
        .FRAME_BYTES (FRAME_LEN)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Model state of the receiver: both banks, the running CRC, the held low CRC byte,
    // the write position, the accepted bank, freshness and the limit register.
    logic [7:0]       shadow_frames [0:2*BANK_STRIDE-1];
    logic [15:0]      run_crc;
    logic [7:0]       crc_low;
    logic [POS_W-1:0] rx_pos;
    logic             live_bank;
    logic             stale_now;
    logic [AGE_W-1:0] age_count;
    logic [AGE_W-1:0] fresh_limit;

    rx_result_t awaited_results [$];

    int  sent_items  = 0;
    int  good_frames = 0;
    int  bad_frames  = 0;
    int  tick_count  = 0;
    int  read_count  = 0;
    int  fails       = 0;
    int  hold_left   = 0;
    bit  steady       = 1'b0;
    bit  hold_request = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Reflected CRC-16, fed one data bit at a time, least significant bit first.
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ data[i];
            c  = c >> 1;
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    // Advances the model by one accepted input transfer and returns the result it should give.
    function automatic rx_result_t predict_transfer(input kind_t k, input logic [7:0] rx,
                                                    input logic [5:0] addr);
        rx_result_t r;
        logic       spare;
        logic [7:0] mode_byte;
        r     = '0;
        spare = ~live_bank;
        case (k)
            KIND_RX_BYTE:
            begin
                if (rx_pos < FRAME_LEN)
                begin
                    // Bytes always land in the bank that does not hold accepted data.
                    shadow_frames[{spare, rx_pos[5:0]}] = rx;
                    if (rx_pos < FRAME_LEN - 2)
                    begin
                        run_crc = crc16_update(run_crc, rx);
                        rx_pos  = rx_pos + 1'b1;
                    end
                    else if (rx_pos == FRAME_LEN - 2)
                    begin
                        crc_low = rx;
                        rx_pos  = rx_pos + 1'b1;
                    end
                    else
                    begin
                        // Last byte: the trailing CRC is little-endian. Good or bad, the
                        // receiver re-arms for the next frame by itself.
                        r.frame_checked = 1'b1;
                        if ({rx, crc_low} == run_crc)
                        begin
                            r.crc_good = 1'b1;
                            live_bank  = spare;
                            stale_now  = 1'b0;
                            age_count  = '0;
                            good_frames++;
                        end
                        else
                        begin
                            bad_frames++;
                        end
                        rx_pos  = '0;
                        run_crc = CRC_INIT;
                    end
                end
                else
                begin
                    rx_pos  = '0;
                    run_crc = CRC_INIT;
                end
            end
            KIND_TICK:
            begin
                tick_count++;
                // The age saturates, so a limit at the top of the range never goes stale.
                if (age_count != AGE_MAX)
                    age_count = age_count + 1'b1;
                if (age_count > fresh_limit)
                    stale_now = 1'b1;
            end
            KIND_START:
            begin
                rx_pos  = '0;
                run_crc = CRC_INIT;
            end
            default:
            begin
                read_count++;
                if (addr < FRAME_LEN)
                    r.read_data = shadow_frames[{live_bank, addr}];
            end
        endcase
        mode_byte       = shadow_frames[{live_bank, 6'(MODE_AT)}];
        r.stale         = stale_now;
        r.accepted_bank = live_bank;
        r.mode_bits     = mode_byte[1:0];
        r.nav_status    = shadow_frames[{live_bank, 6'(STATUS_AT)}];
        return r;
    endfunction

    // Offers one input item from a falling edge and returns at the falling edge after its
    // transfer. Idle gaps are drawn before the item unless the steady stretch is running.
    task automatic put_item(input kind_t k, input logic [7:0] rx, input logic [5:0] addr,
                            input bit typed = 1'b0, input rx_result_t want = '0);
        rx_result_t predicted;
        while (!steady && $urandom_range(0, 99) < 9)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= k;
        in_ch.rx_byte   <= rx;
        in_ch.read_addr <= addr;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predicted = predict_transfer(k, rx, addr);
        awaited_results.push_back(typed ? want : predicted);
        sent_items++;
        @(negedge clk);
    endtask

    // With the given chance in percent, slips a tick or a read in between frame bytes.
    task automatic put_tick_or_read(input int pct);
        if ($urandom_range(0, 99) < pct)
        begin
            if ($urandom_range(0, 1) == 1)
                put_item(KIND_TICK, 8'($urandom), 6'($urandom));
            else
                put_item(KIND_READ, 8'($urandom), 6'($urandom));
        end
    endtask

    // A whole frame with a trailing CRC, correct unless corrupt is set. A frame start leads
    // only when needed or at random, so that the re-arm after a frame end is relied on too.
    task automatic send_frame(input bit corrupt);
        logic [7:0]  body [FRAME_LEN-2];
        logic [15:0] check;
        logic [7:0]  b;
        int          fill;
        fill  = $urandom_range(0, 9);
        check = CRC_INIT;
        if (rx_pos != 0 || $urandom_range(0, 1) == 1)
            put_item(KIND_START, 8'($urandom), 6'($urandom));
        for (int i = 0; i < FRAME_LEN - 2; i++)
        begin
            body[i] = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
            check   = crc16_update(check, body[i]);
        end
        if (corrupt)
        begin
            if ($urandom_range(0, 1) == 1)
                check = check ^ (16'd1 << $urandom_range(0, 15));
            else
                body[$urandom_range(0, FRAME_LEN - 3)] ^= 8'd1 << $urandom_range(0, 7);
        end
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            put_tick_or_read(8);
            if (i < FRAME_LEN - 2)
                b = body[i];
            else if (i == FRAME_LEN - 2)
                b = check[7:0];
            else
                b = check[15:8];
            put_item(KIND_RX_BYTE, b, 6'($urandom));
        end
    endtask

    // Random traffic up to the given item count: mostly whole frames, some cut-off or
    // abandoned frames, and runs of ticks and reads.
    task automatic run_mix(input int upto);
        int pick;
        int n;
        while (sent_items < upto)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                send_frame($urandom_range(0, 4) == 0);
            end
            else if (pick < 70)
            begin
                put_item(KIND_START, 8'($urandom), 6'($urandom));
                n = $urandom_range(1, FRAME_LEN - 1);
                repeat (n)
                    put_item(KIND_RX_BYTE, 8'($urandom), 6'($urandom));
                if ($urandom_range(0, 1) == 1)
                    put_item(KIND_START, 8'($urandom), 6'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 20))
                    put_tick_or_read(100);
            end
        end
    endtask

    // Lets every outstanding result drain, so that the block is idle.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Writes the freshness limit while the block is idle and mirrors it in the model.
    task automatic set_limit(input logic [AGE_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we      <= 1'b0;
        fresh_limit = v;
        @(negedge clk);
    endtask

    // Result side. Ready drops with a chance of about nine in a hundred, never during the steady
    // stretch, and for a long hold-off when the stimulus asks for one; the hold-off is
    // counted here so that the sender keeps offering items meanwhile and the block fills up.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= steady || ($urandom_range(0, 99) >= 9);
            end
        end
    end

    // Every result transfer is checked field by field against the oldest expectation.
    always @(posedge clk)
    begin
        rx_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result transfer arrived with no result awaited");
                fails++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (out_ch.frame_checked !== want.frame_checked)
                begin
                    $error("frame_checked: expected %0d, got %0d",
                           want.frame_checked, out_ch.frame_checked);
                    fails++;
                end
                if (out_ch.crc_good !== want.crc_good)
                begin
                    $error("crc_good: expected %0d, got %0d", want.crc_good, out_ch.crc_good);
                    fails++;
                end
                if (out_ch.stale !== want.stale)
                begin
                    $error("stale: expected %0d, got %0d", want.stale, out_ch.stale);
                    fails++;
                end
                if (out_ch.accepted_bank !== want.accepted_bank)
                begin
                    $error("accepted_bank: expected %0d, got %0d",
                           want.accepted_bank, out_ch.accepted_bank);
                    fails++;
                end
                if (out_ch.mode_bits !== want.mode_bits)
                begin
                    $error("mode_bits: expected %0d, got %0d", want.mode_bits, out_ch.mode_bits);
                    fails++;
                end
                if (out_ch.nav_status !== want.nav_status)
                begin
                    $error("nav_status: expected 0x%02h, got 0x%02h",
                           want.nav_status, out_ch.nav_status);
                    fails++;
                end
                if (out_ch.read_data !== want.read_data)
                begin
                    $error("read_data: expected 0x%02h, got 0x%02h",
                           want.read_data, out_ch.read_data);
                    fails++;
                end
            end
        end
    end

    // Stimulus. Each phase runs with one freshness limit; the limit is only changed once
    // all results of the previous phase have come back.
    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        in_ch.valid     = 1'b0;
        in_ch.kind      = KIND_RX_BYTE;
        in_ch.rx_byte   = '0;
        in_ch.read_addr = '0;

        for (int i = 0; i < 2 * BANK_STRIDE; i++)
            shadow_frames[i] = 8'h00;
        run_crc     = CRC_INIT;
        crc_low     = '0;
        rx_pos      = '0;
        live_bank   = 1'b0;
        stale_now   = 1'b1;
        age_count   = '0;
        fresh_limit = LIMIT_RESET;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows run with the limit still at its reset value.
        for (int i = 0; i < DIRECTED_ROWS; i++)
            put_item(DIRECTED[i].kind, DIRECTED[i].rx_byte, DIRECTED[i].read_addr,
                     DIRECTED[i].typed, DIRECTED[i].want);

        // Lowest limit: any tick after a good frame marks the data stale.
        settle();
        set_limit('0);
        run_mix(sent_items + 150);

        // A small limit, with a long hold-off on the result side at the start so that the
        // input stalls, followed by a stretch in which neither side idles.
        settle();
        set_limit(10'd17);
        hold_request = 1'b1;
        run_mix(sent_items + 130);
        steady = 1'b1;
        run_mix(sent_items + 100);
        steady = 1'b0;

        // Highest limit: after a good frame, forty ticks leave the data fresh. Lowering the
        // limit below the age reached must then make the next tick mark it stale.
        settle();
        set_limit(AGE_MAX);
        send_frame(1'b0);
        for (int i = 0; i < 40; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                put_item(KIND_READ, 8'($urandom), 6'($urandom));
            put_item(KIND_TICK, 8'($urandom), 6'($urandom));
        end
        settle();
        set_limit(10'd20);
        put_item(KIND_TICK, 8'($urandom), 6'($urandom));
        put_item(KIND_READ, 8'($urandom), 6'($urandom));

        settle();
        set_limit(10'd5);
        run_mix(sent_items + 90);

        settle();
        repeat (8) @(posedge clk);

        $display("Run covered %0d input transfers: %0d frames with a good CRC, %0d with a bad one,",
                 sent_items, good_frames, bad_frames);
        $display("%0d ticks and %0d reads, over freshness limits 500, 0, 17, 1023, 20 and 5.",
                 tick_count, read_count);
        if (fails == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #3000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/cfdb_pkg.sv
rtl/cfdb_in_if.sv
rtl/cfdb_out_if.sv
rtl/cfdb_frame_mem.sv
rtl/cfdb_rx_ctrl.sv
rtl/crc_checked_frame_double_buffer_top.sv
rtl/cfdb_checker.sv
test/tb_crc_checked_frame_double_buffer_top.sv
